[src/triplet_angle_distance_histogram_top_defines.svh]
// Assertion macros shared by the histogram block.
`ifndef TRIPLET_ANGLE_DISTANCE_HISTOGRAM_TOP_DEFINES_SVH
`define TRIPLET_ANGLE_DISTANCE_HISTOGRAM_TOP_DEFINES_SVH

// Overlapping implication, sampled on clk and disabled during reset.
`define TADH_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tadh: implication check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define TADH_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tadh: next-cycle check failed");

`endif

[src/tadh_pkg.sv]
// Types, constants and tables shared by the triplet histogram modules.
`timescale 1ns / 1ps
package tadh_pkg;
	localparam int COORD_BITS = 24;
	localparam int MAX_DIST_BINS = 16;
	localparam int MAX_ANGLE_BINS = 32;
	localparam int DIST_W = $clog2(MAX_DIST_BINS);
	localparam int ANGLE_W = $clog2(MAX_ANGLE_BINS);
	localparam int SEL_W = ANGLE_W + 2 * DIST_W;
	localparam int HIST_DEPTH = MAX_ANGLE_BINS * MAX_DIST_BINS * MAX_DIST_BINS;
	localparam int COUNT_W = 32;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int MUL_W = 32;
	localparam int PROD_W = 2 * MUL_W;
	localparam int ACC_W = 2 * COORD_BITS + 2;
	localparam int R_W = COORD_BITS + 2;
	localparam int P_W = 2 * R_W;
	localparam int Q_W = 31;
	localparam int SQ_OP_W = 64;
	localparam int SQ_ROOT_W = SQ_OP_W / 2;
	localparam int XY_W = 34;
	localparam int Z_W = 34;
	localparam int ANG_W = 32;
	localparam int CORDIC_STEPS = 28;
	localparam int STEP_W = 5;
	localparam int BIN_SHIFT = 28;

	localparam logic [CFG_INDEX_W-1:0] CFG_LOWER_CUTOFF = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_DISTANCE_SCALE = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_DISTANCE_BINS = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_ANGLE_BINS = 2'd3;

	localparam logic [2:0] STAT_COUNTED = 3'd0;
	localparam logic [2:0] STAT_BEYOND = 3'd1;
	localparam logic [2:0] STAT_BELOW = 3'd2;
	localparam logic [2:0] STAT_ZERO = 3'd3;
	localparam logic [2:0] STAT_READ = 3'd4;

	localparam logic [Q_W-1:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [SQ_OP_W-1:0] ONE_Q60 = 64'h1000_0000_0000_0000;
	localparam logic [Z_W-1:0] HALF_PI_UNITS = 34'h0_4000_0000;
	localparam logic [Z_W-2:0] PI_UNITS = 33'h0_8000_0000;

	typedef struct packed {
		logic mode;
		logic signed [COORD_BITS-1:0] ij_dx;
		logic signed [COORD_BITS-1:0] ij_dy;
		logic signed [COORD_BITS-1:0] ij_dz;
		logic signed [COORD_BITS-1:0] ik_dx;
		logic signed [COORD_BITS-1:0] ik_dy;
		logic signed [COORD_BITS-1:0] ik_dz;
		logic [SEL_W-1:0] bin_select;
	} tadh_in_t;

	typedef struct packed {
		logic [2:0] status;
		logic [ANGLE_W-1:0] angle_bin;
		logic [DIST_W-1:0] near_bin;
		logic [DIST_W-1:0] far_bin;
		logic [COUNT_W-1:0] bin_count;
	} tadh_out_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROD,
		ST_SQRT_GO,
		ST_SQRT_WAIT,
		ST_CHECK,
		ST_BIN,
		ST_BIN_WAIT,
		ST_BIN_CHK,
		ST_PMUL,
		ST_PMUL_WAIT,
		ST_DIV_INIT,
		ST_DIV,
		ST_QQ,
		ST_QQ_WAIT,
		ST_CORDIC_GO,
		ST_CORDIC_WAIT,
		ST_TB,
		ST_TB_WAIT,
		ST_READ,
		ST_UPDATE,
		ST_FINISH
	} tadh_state_t;

	typedef enum logic [3:0] {
		MT_NONE,
		MT_SAA,
		MT_SBB,
		MT_SDD,
		MT_DOT,
		MT_BIN,
		MT_P,
		MT_QQ,
		MT_TB
	} tadh_mtgt_t;

	function automatic logic [29:0] atan_unit(input logic [STEP_W-1:0] i);
		logic [29:0] v;
		case (i)
			5'd0: v = 30'd536870912;
			5'd1: v = 30'd316933406;
			5'd2: v = 30'd167458907;
			5'd3: v = 30'd85004756;
			5'd4: v = 30'd42667331;
			5'd5: v = 30'd21354465;
			5'd6: v = 30'd10679838;
			5'd7: v = 30'd5340245;
			5'd8: v = 30'd2670163;
			5'd9: v = 30'd1335087;
			5'd10: v = 30'd667544;
			5'd11: v = 30'd333772;
			5'd12: v = 30'd166886;
			5'd13: v = 30'd83443;
			5'd14: v = 30'd41722;
			5'd15: v = 30'd20861;
			5'd16: v = 30'd10430;
			5'd17: v = 30'd5215;
			5'd18: v = 30'd2608;
			5'd19: v = 30'd1304;
			5'd20: v = 30'd652;
			5'd21: v = 30'd326;
			5'd22: v = 30'd163;
			5'd23: v = 30'd81;
			5'd24: v = 30'd41;
			5'd25: v = 30'd20;
			5'd26: v = 30'd10;
			5'd27: v = 30'd5;
			default: v = 30'd0;
		endcase
		return v;
	endfunction
endpackage

[src/tadh_ram.sv]
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module tadh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8192
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

[src/tadh_sqrt.sv]
// Iterative floor square root, one result bit per cycle.
`timescale 1ns / 1ps
module tadh_sqrt (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [tadh_pkg::SQ_OP_W-1:0] radicand,
	output logic busy,
	output logic [tadh_pkg::SQ_ROOT_W-1:0] root
);
	import tadh_pkg::*;

	localparam int REM_W = SQ_ROOT_W + 2;
	localparam int CNT_W = $clog2(SQ_ROOT_W);

	logic busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SQ_OP_W-1:0] op_q;
	logic [REM_W-1:0] rem_q;
	logic [SQ_ROOT_W-1:0] root_q;
	logic [REM_W+1:0] cur;
	logic [REM_W+1:0] trial;
	logic ge;

	assign cur = {rem_q, op_q[SQ_OP_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge = cur >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(SQ_ROOT_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			op_q <= {op_q[SQ_OP_W-3:0], 2'b00};
			if (ge) begin
				rem_q <= REM_W'(cur - trial);
				root_q <= {root_q[SQ_ROOT_W-2:0], 1'b1};
			end else begin
				rem_q <= REM_W'(cur);
				root_q <= {root_q[SQ_ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign root = root_q;
endmodule

[src/tadh_cordic.sv]
// CORDIC vectoring unit that turns a cosine and sine pair into an angle.
`timescale 1ns / 1ps
module tadh_cordic (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [tadh_pkg::XY_W-1:0] x0,
	input logic signed [tadh_pkg::XY_W-1:0] y0,
	input logic signed [tadh_pkg::Z_W-1:0] z0,
	output logic busy,
	output logic [tadh_pkg::ANG_W-1:0] angle
);
	import tadh_pkg::*;

	logic busy_q;
	logic [STEP_W-1:0] i_q;
	logic signed [XY_W-1:0] x_q;
	logic signed [XY_W-1:0] y_q;
	logic signed [Z_W-1:0] z_q;
	logic signed [XY_W-1:0] xs;
	logic signed [XY_W-1:0] ys;
	logic signed [Z_W-1:0] at;

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = $signed(Z_W'(atan_unit(i_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			i_q <= '0;
		end else if (busy_q) begin
			i_q <= i_q + 1'b1;
			if (i_q == STEP_W'(CORDIC_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= z0;
		end else if (busy_q) begin
			if (!y_q[XY_W-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
	end

	always_comb begin
		if (z_q[Z_W-1]) begin
			angle = '0;
		end else if (z_q[Z_W-2:0] > PI_UNITS) begin
			angle = ANG_W'(PI_UNITS);
		end else begin
			angle = ANG_W'(z_q[Z_W-2:0]);
		end
	end

	assign busy = busy_q;
endmodule

[src/triplet_angle_distance_histogram_top.sv]
// Top level of the triplet angle and distance histogram block.
`timescale 1ns / 1ps
`include "triplet_angle_distance_histogram_top_defines.svh"
// Each input transaction either tallies one triplet (mode 0) or reads and
// clears one histogram bin (mode 1); each produces exactly one output
// transaction on out_data. Both channels use valid and ready.
// Registers are written through cfg_write, cfg_index and cfg_data. The user
// must write them only while the block is idle; the block does not enforce it.
// A counted tally runs the products on the shared 32 by 32 multiplier, four
// square roots on the shared root unit, a divider, CORDIC and a
// read-modify-write of the bin memory before out_valid rises. When the cosine
// clamps to one the divider is skipped; a zero or short length ends after the
// third root and an out-of-range bin after the length binning.
// A read goes through the read and update states of the bin memory. in_ready
// rises together with out_valid, so one item is in work at a time.
// After reset the block sweeps the 8192 entry histogram to zero, one entry
// per cycle, and holds in_ready low until the sweep is done.
// A finished result waits in the output register while out_ready is low;
// the block accepts the next transaction meanwhile and stalls only when a
// second result would overwrite the waiting one.
module triplet_angle_distance_histogram_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input tadh_pkg::tadh_in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output tadh_pkg::tadh_out_t out_data,
	input logic cfg_write,
	input logic [tadh_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [tadh_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tadh_pkg::*;

	localparam int CNT_W = 5;
	localparam logic [CNT_W-1:0] PROD_LAST = 5'd12;
	localparam logic [CNT_W-1:0] DIV_LAST = 5'd29;
	localparam logic [CNT_W-1:0] ROOT_JK = 5'd2;
	localparam logic [CNT_W-1:0] ROOT_SIN = 5'd3;
	localparam int DM_W = COORD_BITS + 1;
	localparam int BIN_HI_W = PROD_W - BIN_SHIFT;

	tadh_state_t state_q, state_d;
	logic [SEL_W-1:0] clr_q;
	logic [CNT_W-1:0] cnt_q;

	logic [23:0] lower_q;
	logic [31:0] scale_q;
	logic [4:0] dbins_q;
	logic [5:0] abins_q;
	logic [4:0] nd;
	logic [5:0] na;

	tadh_in_t in_q;
	tadh_out_t res_q, out_q;
	logic out_valid_q;
	logic load_out;

	logic [ACC_W-1:0] saa_q, sbb_q, sdd_q, dpos_q, dneg_q;
	logic [R_W-1:0] rij_q, rik_q, rjk_q;
	logic [DIST_W-1:0] bij_q, bik_q;
	logic range_bad_q;
	logic [P_W-1:0] p_q, rem_q, rem2;
	logic neg_q;
	logic [Q_W-1:0] quo_q, s_q;
	logic [SQ_OP_W-1:0] rad_q;
	logic [ANGLE_W-1:0] tb_q;
	logic [SEL_W-1:0] idx_q;

	logic [MUL_W-1:0] mul_a, mul_b;
	tadh_mtgt_t mtgt, mtgt_s1;
	logic [PROD_W-1:0] prod_s1;
	logic msgn_s1;
	logic [1:0] mbin_s1;
	logic [BIN_HI_W-1:0] bin_hi;
	logic [7:0] tb_raw;

	logic [1:0] comp, term;
	logic signed [COORD_BITS-1:0] ca, cb;
	logic signed [COORD_BITS:0] a_ext, b_ext, d_ext, ma_w, mb_w;
	logic signed [COORD_BITS+1:0] dd_ext, md_w;
	logic [COORD_BITS-1:0] ma, mb;
	logic [DM_W-1:0] md;
	logic [R_W-1:0] rsel, dsub;

	logic sq_start, sq_busy;
	logic [SQ_OP_W-1:0] sq_rad;
	logic [SQ_ROOT_W-1:0] sq_root;
	logic cd_start, cd_busy;
	logic signed [XY_W-1:0] cd_x0, cd_y0;
	logic signed [Z_W-1:0] cd_z0;
	logic [ANG_W-1:0] cd_angle;

	logic ram_we;
	logic [SEL_W-1:0] ram_waddr, ram_raddr;
	logic [COUNT_W-1:0] ram_wdata, ram_rdata, cnt_inc;

	logic dneg_gt;
	logic [ACC_W-1:0] dm;
	logic any_zero, any_below;

	tadh_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(sq_start),
		.radicand(sq_rad),
		.busy(sq_busy),
		.root(sq_root)
	);

	tadh_cordic u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(cd_start),
		.x0(cd_x0),
		.y0(cd_y0),
		.z0(cd_z0),
		.busy(cd_busy),
		.angle(cd_angle)
	);

	tadh_ram #(
		.WIDTH(COUNT_W),
		.DEPTH(HIST_DEPTH)
	) u_hist (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= '0;
			scale_q <= 32'd65536;
			dbins_q <= 5'd16;
			abins_q <= 6'd32;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_LOWER_CUTOFF: lower_q <= cfg_data[23:0];
				CFG_DISTANCE_SCALE: scale_q <= cfg_data[31:0];
				CFG_DISTANCE_BINS: dbins_q <= cfg_data[4:0];
				CFG_ANGLE_BINS: abins_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	assign nd = (dbins_q == '0) ? 5'd1 :
		((dbins_q > 5'(MAX_DIST_BINS)) ? 5'(MAX_DIST_BINS) : dbins_q);
	assign na = (abins_q == '0) ? 6'd1 :
		((abins_q > 6'(MAX_ANGLE_BINS)) ? 6'(MAX_ANGLE_BINS) : abins_q);

	assign comp = cnt_q[3:2];
	assign term = cnt_q[1:0];

	always_comb begin
		case (comp)
			2'd0: begin
				ca = in_q.ij_dx;
				cb = in_q.ik_dx;
			end
			2'd1: begin
				ca = in_q.ij_dy;
				cb = in_q.ik_dy;
			end
			default: begin
				ca = in_q.ij_dz;
				cb = in_q.ik_dz;
			end
		endcase
	end

	assign a_ext = {ca[COORD_BITS-1], ca};
	assign b_ext = {cb[COORD_BITS-1], cb};
	assign d_ext = b_ext - a_ext;
	assign dd_ext = {d_ext[COORD_BITS], d_ext};
	assign ma_w = a_ext[COORD_BITS] ? -a_ext : a_ext;
	assign mb_w = b_ext[COORD_BITS] ? -b_ext : b_ext;
	assign md_w = dd_ext[COORD_BITS+1] ? -dd_ext : dd_ext;
	assign ma = ma_w[COORD_BITS-1:0];
	assign mb = mb_w[COORD_BITS-1:0];
	assign md = md_w[DM_W-1:0];

	always_comb begin
		case (cnt_q[1:0])
			2'd0: rsel = rij_q;
			2'd1: rsel = rik_q;
			default: rsel = rjk_q;
		endcase
	end
	assign dsub = rsel - R_W'(lower_q);

	assign dneg_gt = dneg_q > dpos_q;
	assign dm = dneg_gt ? (dneg_q - dpos_q) : (dpos_q - dneg_q);
	assign rem2 = {rem_q[P_W-2:0], 1'b0};
	assign any_zero = (rij_q == '0) || (rik_q == '0) || (rjk_q == '0);
	assign any_below = (rij_q < R_W'(lower_q)) || (rik_q < R_W'(lower_q)) ||
		(rjk_q < R_W'(lower_q));
	assign cnt_inc = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;
	assign bin_hi = prod_s1[PROD_W-1:BIN_SHIFT];
	assign tb_raw = prod_s1[38:31];

	assign cd_x0 = neg_q ? XY_W'(s_q) : XY_W'(quo_q);
	assign cd_y0 = neg_q ? XY_W'(quo_q) : XY_W'(s_q);
	assign cd_z0 = neg_q ? $signed(HALF_PI_UNITS) : '0;

	always_comb begin
		case (cnt_q[1:0])
			2'd0: sq_rad = SQ_OP_W'(saa_q);
			2'd1: sq_rad = SQ_OP_W'(sbb_q);
			2'd2: sq_rad = SQ_OP_W'(sdd_q);
			default: sq_rad = rad_q;
		endcase
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		ram_we = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '0;
		ram_raddr = in_q.mode ? in_q.bin_select : {tb_q, bij_q, bik_q};
		mul_a = '0;
		mul_b = '0;
		mtgt = MT_NONE;
		sq_start = 1'b0;
		cd_start = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_q;
				if (clr_q == SEL_W'(HIST_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = in_data.mode ? ST_READ : ST_PROD;
				end
			end
			ST_PROD: begin
				if (cnt_q == PROD_LAST) begin
					state_d = ST_SQRT_GO;
				end else begin
					case (term)
						2'd0: begin
							mul_a = MUL_W'(ma);
							mul_b = MUL_W'(ma);
							mtgt = MT_SAA;
						end
						2'd1: begin
							mul_a = MUL_W'(mb);
							mul_b = MUL_W'(mb);
							mtgt = MT_SBB;
						end
						2'd2: begin
							mul_a = MUL_W'(md);
							mul_b = MUL_W'(md);
							mtgt = MT_SDD;
						end
						default: begin
							mul_a = MUL_W'(ma);
							mul_b = MUL_W'(mb);
							mtgt = MT_DOT;
						end
					endcase
				end
			end
			ST_SQRT_GO: begin
				sq_start = 1'b1;
				state_d = ST_SQRT_WAIT;
			end
			ST_SQRT_WAIT: begin
				if (!sq_busy) begin
					if (cnt_q == ROOT_SIN) begin
						state_d = ST_CORDIC_GO;
					end else if (cnt_q == ROOT_JK) begin
						state_d = ST_CHECK;
					end else begin
						state_d = ST_SQRT_GO;
					end
				end
			end
			ST_CHECK: begin
				state_d = (any_zero || any_below) ? ST_FINISH : ST_BIN;
			end
			ST_BIN: begin
				mul_a = MUL_W'(dsub);
				mul_b = scale_q;
				mtgt = MT_BIN;
				if (cnt_q == ROOT_JK) begin
					state_d = ST_BIN_WAIT;
				end
			end
			ST_BIN_WAIT: state_d = ST_BIN_CHK;
			ST_BIN_CHK: state_d = range_bad_q ? ST_FINISH : ST_PMUL;
			ST_PMUL: begin
				mul_a = MUL_W'(rij_q);
				mul_b = MUL_W'(rik_q);
				mtgt = MT_P;
				state_d = ST_PMUL_WAIT;
			end
			ST_PMUL_WAIT: state_d = ST_DIV_INIT;
			ST_DIV_INIT: begin
				state_d = (P_W'(dm) >= p_q) ? ST_QQ : ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == DIV_LAST) begin
					state_d = ST_QQ;
				end
			end
			ST_QQ: begin
				mul_a = MUL_W'(quo_q);
				mul_b = MUL_W'(quo_q);
				mtgt = MT_QQ;
				state_d = ST_QQ_WAIT;
			end
			ST_QQ_WAIT: state_d = ST_SQRT_GO;
			ST_CORDIC_GO: begin
				cd_start = 1'b1;
				state_d = ST_CORDIC_WAIT;
			end
			ST_CORDIC_WAIT: begin
				if (!cd_busy) begin
					state_d = ST_TB;
				end
			end
			ST_TB: begin
				mul_a = cd_angle;
				mul_b = MUL_W'(na);
				mtgt = MT_TB;
				state_d = ST_TB_WAIT;
			end
			ST_TB_WAIT: state_d = ST_READ;
			ST_READ: state_d = ST_UPDATE;
			ST_UPDATE: begin
				ram_we = 1'b1;
				ram_wdata = in_q.mode ? '0 : cnt_inc;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			mtgt_s1 <= MT_NONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			mtgt_s1 <= mtgt;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		msgn_s1 <= ca[COORD_BITS-1] ^ cb[COORD_BITS-1];
		mbin_s1 <= cnt_q[1:0];
		if (load_out) begin
			out_q <= res_q;
		end

		case (state_q)
			ST_IDLE: begin
				in_q <= in_data;
				saa_q <= '0;
				sbb_q <= '0;
				sdd_q <= '0;
				dpos_q <= '0;
				dneg_q <= '0;
				range_bad_q <= 1'b0;
				cnt_q <= '0;
			end
			ST_PROD: cnt_q <= (cnt_q == PROD_LAST) ? '0 : cnt_q + 1'b1;
			ST_SQRT_WAIT: begin
				if (!sq_busy) begin
					case (cnt_q[1:0])
						2'd0: rij_q <= sq_root[R_W-1:0];
						2'd1: rik_q <= sq_root[R_W-1:0];
						2'd2: rjk_q <= sq_root[R_W-1:0];
						default: s_q <= sq_root[Q_W-1:0];
					endcase
					if (cnt_q < ROOT_JK) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
			end
			ST_CHECK: begin
				cnt_q <= '0;
				res_q <= '{status: any_zero ? STAT_ZERO : STAT_BELOW,
					angle_bin: '0, near_bin: '0, far_bin: '0, bin_count: '0};
			end
			ST_BIN: cnt_q <= cnt_q + 1'b1;
			ST_BIN_CHK: begin
				res_q <= '{status: STAT_BEYOND,
					angle_bin: '0, near_bin: '0, far_bin: '0, bin_count: '0};
			end
			ST_DIV_INIT: begin
				neg_q <= dneg_gt;
				cnt_q <= '0;
				rem_q <= P_W'(dm);
				quo_q <= (P_W'(dm) >= p_q) ? ONE_Q30 : '0;
			end
			ST_DIV: begin
				cnt_q <= cnt_q + 1'b1;
				if (rem2 >= p_q) begin
					rem_q <= rem2 - p_q;
					quo_q <= {quo_q[Q_W-2:0], 1'b1};
				end else begin
					rem_q <= rem2;
					quo_q <= {quo_q[Q_W-2:0], 1'b0};
				end
			end
			ST_QQ: cnt_q <= ROOT_SIN;
			ST_READ: idx_q <= ram_raddr;
			ST_UPDATE: begin
				res_q.status <= in_q.mode ? STAT_READ : STAT_COUNTED;
				res_q.angle_bin <= idx_q[SEL_W-1 -: ANGLE_W];
				res_q.near_bin <= idx_q[2*DIST_W-1:DIST_W];
				res_q.far_bin <= idx_q[DIST_W-1:0];
				res_q.bin_count <= in_q.mode ? ram_rdata : cnt_inc;
			end
			default: ;
		endcase

		case (mtgt_s1)
			MT_SAA: saa_q <= saa_q + prod_s1[ACC_W-1:0];
			MT_SBB: sbb_q <= sbb_q + prod_s1[ACC_W-1:0];
			MT_SDD: sdd_q <= sdd_q + prod_s1[ACC_W-1:0];
			MT_DOT: begin
				if (msgn_s1) begin
					dneg_q <= dneg_q + prod_s1[ACC_W-1:0];
				end else begin
					dpos_q <= dpos_q + prod_s1[ACC_W-1:0];
				end
			end
			MT_BIN: begin
				if (bin_hi >= BIN_HI_W'(nd)) begin
					range_bad_q <= 1'b1;
				end
				case (mbin_s1)
					2'd0: bij_q <= bin_hi[DIST_W-1:0];
					2'd1: bik_q <= bin_hi[DIST_W-1:0];
					default: ;
				endcase
			end
			MT_P: p_q <= prod_s1[P_W-1:0];
			MT_QQ: rad_q <= ONE_Q60 - prod_s1;
			MT_TB: begin
				tb_q <= (tb_raw >= 8'(na)) ? ANGLE_W'(na - 1'b1) : tb_raw[ANGLE_W-1:0];
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	`TADH_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`TADH_ASSERT_IMPL(a_clear_blocks_input, state_q == ST_CLEAR, !in_ready)
	`TADH_ASSERT_IMPL(a_counted_nonzero, out_valid && out_data.status == STAT_COUNTED, out_data.bin_count != '0)
endmodule

[bench/triplet_angle_distance_histogram_checker.sv]
// Checker for the triplet histogram: predicts every result and compares it.
`timescale 1ns / 1ps
module triplet_angle_distance_histogram_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input tadh_pkg::tadh_in_t in_data,
	input logic out_valid,
	input logic out_ready,
	input tadh_pkg::tadh_out_t out_data,
	input logic cfg_write,
	input logic [tadh_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [tadh_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic in_fire,
	output logic out_fire,
	output logic [tadh_pkg::SEL_W-1:0] last_hit,
	output int pending,
	output int failures
);
	import tadh_pkg::*;

	localparam longint ATAN_TAB [CORDIC_STEPS] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
	};

	logic [COUNT_W-1:0] hist_model [HIST_DEPTH];
	logic [23:0] min_dist;
	logic [31:0] dist_scale;
	logic [4:0] dist_bins;
	logic [5:0] ang_bins;
	tadh_out_t expected_q [$];
	int mismatches;

	function automatic longint unsigned root64(input longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint unsigned length_bin(input longint unsigned r);
		longint unsigned d, hi, lo;
		d = r - min_dist;
		hi = d >> BIN_SHIFT;
		lo = d & 64'h0FFF_FFFF;
		return hi * dist_scale + ((lo * dist_scale) >> BIN_SHIFT);
	endfunction

	function automatic longint unsigned triplet_angle(input longint unsigned dpos,
			input longint unsigned dneg, input longint unsigned p);
		logic neg, carry;
		longint unsigned dm, q, r, s;
		longint x, y, z, xs, ys;
		neg = dneg > dpos;
		dm = neg ? dneg - dpos : dpos - dneg;
		q = 0;
		r = dm;
		if (dm >= p) begin
			q = 64'd1 << 30;
		end else begin
			for (int i = 0; i < 30; i++) begin
				carry = r[63];
				r = r << 1;
				q = q << 1;
				if (carry || r >= p) begin
					r = r - p;
					q = q | 64'd1;
				end
			end
		end
		s = root64((64'd1 << 60) - q * q);
		if (!neg) begin
			x = q; y = s; z = 0;
		end else begin
			x = s; y = q; z = 64'd1 << 30;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys; y = y - xs; z = z + ATAN_TAB[i];
			end else begin
				x = x - ys; y = y + xs; z = z - ATAN_TAB[i];
			end
		end
		if (z < 0) z = 0;
		if (z > (64'd1 << 31)) z = 64'd1 << 31;
		return z;
	endfunction

	task automatic predict_result(input tadh_in_t it);
		tadh_out_t res;
		longint a [3], b [3];
		longint unsigned ma, mb, md, saa, sbb, sdd, dpos, dneg;
		longint unsigned rij, rik, rjk, bij, bik, bjk, z, tb, nd, na;
		int idx;
		res = '0;
		if (it.mode) begin
			res.status = STAT_READ;
			res.angle_bin = ANGLE_W'(it.bin_select / (MAX_DIST_BINS * MAX_DIST_BINS));
			res.near_bin = DIST_W'((it.bin_select / MAX_DIST_BINS) % MAX_DIST_BINS);
			res.far_bin = DIST_W'(it.bin_select % MAX_DIST_BINS);
			if (it.bin_select < HIST_DEPTH) begin
				res.bin_count = hist_model[it.bin_select];
				hist_model[it.bin_select] = '0;
			end
		end else begin
			a[0] = it.ij_dx; a[1] = it.ij_dy; a[2] = it.ij_dz;
			b[0] = it.ik_dx; b[1] = it.ik_dy; b[2] = it.ik_dz;
			saa = 0; sbb = 0; sdd = 0; dpos = 0; dneg = 0;
			nd = (dist_bins < 1) ? 1 : (dist_bins > MAX_DIST_BINS) ? MAX_DIST_BINS : dist_bins;
			na = (ang_bins < 1) ? 1 : (ang_bins > MAX_ANGLE_BINS) ? MAX_ANGLE_BINS : ang_bins;
			for (int c = 0; c < 3; c++) begin
				ma = (a[c] < 0) ? -a[c] : a[c];
				mb = (b[c] < 0) ? -b[c] : b[c];
				md = (b[c] - a[c] < 0) ? a[c] - b[c] : b[c] - a[c];
				saa += ma * ma;
				sbb += mb * mb;
				sdd += md * md;
				if ((a[c] < 0) != (b[c] < 0)) dneg += ma * mb;
				else dpos += ma * mb;
			end
			rij = root64(saa);
			rik = root64(sbb);
			rjk = root64(sdd);
			if (rij == 0 || rik == 0 || rjk == 0) begin
				res.status = STAT_ZERO;
			end else if (rij < min_dist || rik < min_dist || rjk < min_dist) begin
				res.status = STAT_BELOW;
			end else begin
				bij = length_bin(rij);
				bik = length_bin(rik);
				bjk = length_bin(rjk);
				if (bij >= nd || bik >= nd || bjk >= nd) begin
					res.status = STAT_BEYOND;
				end else begin
					z = triplet_angle(dpos, dneg, rij * rik);
					tb = (z * na) >> 31;
					if (tb >= na) tb = na - 1;
					idx = int'((tb * MAX_DIST_BINS + bij) * MAX_DIST_BINS + bik);
					if (hist_model[idx] != 32'hFFFF_FFFF) hist_model[idx] = hist_model[idx] + 1;
					res.status = STAT_COUNTED;
					res.bin_count = hist_model[idx];
					res.angle_bin = ANGLE_W'(tb);
					res.near_bin = DIST_W'(bij);
					res.far_bin = DIST_W'(bik);
					last_hit <= SEL_W'(idx);
				end
			end
		end
		expected_q.push_back(res);
	endtask

	always @(posedge clk or negedge arst_n) begin
		tadh_out_t exp_res;
		if (!arst_n) begin
			for (int i = 0; i < HIST_DEPTH; i++) hist_model[i] = '0;
			min_dist = '0;
			dist_scale = 32'd65536;
			dist_bins = 5'd16;
			ang_bins = 6'd32;
			expected_q.delete();
			in_fire <= 1'b0;
			out_fire <= 1'b0;
			last_hit <= '0;
			pending <= 0;
			failures <= 0;
			mismatches = 0;
		end else begin
			in_fire <= in_valid && in_ready;
			out_fire <= out_valid && out_ready;
			if (cfg_write) begin
				case (cfg_index)
					CFG_LOWER_CUTOFF: min_dist = cfg_data[23:0];
					CFG_DISTANCE_SCALE: dist_scale = cfg_data;
					CFG_DISTANCE_BINS: dist_bins = cfg_data[4:0];
					CFG_ANGLE_BINS: ang_bins = cfg_data[5:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) predict_result(in_data);
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected output transaction: %p", out_data);
				end else begin
					exp_res = expected_q.pop_front();
					if (out_data !== exp_res) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Mismatch: expected %p, actual %p", exp_res, out_data);
					end
				end
			end
			pending <= expected_q.size();
			failures <= mismatches;
		end
	end
endmodule

[bench/triplet_angle_distance_histogram_top_test.sv]
// Testbench top: stimulus, configuration phases, watchdog and verdict.
`timescale 1ns / 1ps
module triplet_angle_distance_histogram_top_test;
	import tadh_pkg::*;

	localparam int IDLE_LIMIT = 30000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	tadh_in_t in_data;
	logic out_valid;
	logic out_ready;
	tadh_out_t out_data;
	logic cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_fire;
	logic out_fire;
	logic [SEL_W-1:0] last_hit;
	int pending;
	int failures;
	int idle_cycles;
	logic quiet;
	longint span;

	triplet_angle_distance_histogram_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	triplet_angle_distance_histogram_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_fire(in_fire), .out_fire(out_fire), .last_hit(last_hit),
		.pending(pending), .failures(failures)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("triplet_angle_distance_histogram_top_test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = quiet ? 0 : $urandom_range(17);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(negedge clk); while (!out_fire);
		end
	end

	task automatic send_item(input tadh_in_t it);
		int gap;
		gap = quiet ? 0 : $urandom_range(17);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(negedge clk); while (!in_fire);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
	endtask

	task automatic configure(input logic [31:0] lower, input logic [31:0] scale,
			input logic [31:0] dbins, input logic [31:0] abins);
		longint w, nd;
		drain();
		set_reg(CFG_LOWER_CUTOFF, lower);
		set_reg(CFG_DISTANCE_SCALE, scale);
		set_reg(CFG_DISTANCE_BINS, dbins);
		set_reg(CFG_ANGLE_BINS, abins);
		cfg_write <= 1'b0;
		w = (scale == 0) ? 65536 : (64'd1 << 28) / scale;
		if (w < 1) w = 1;
		nd = (dbins[4:0] < 1) ? 1 : (dbins[4:0] > 16) ? 16 : dbins[4:0];
		span = lower[23:0] + w * nd / 2 + 1;
		if (span > 8388607) span = 8388607;
	endtask

	function automatic int near_coord();
		return int'($urandom_range(int'(2 * span))) - int'(span);
	endfunction

	function automatic tadh_in_t random_item();
		logic [159:0] noise;
		noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
		return noise[$bits(tadh_in_t)-1:0];
	endfunction

	function automatic tadh_in_t tally(input int ax, input int ay, input int az,
			input int bx, input int by, input int bz);
		tadh_in_t it;
		it = '0;
		it.ij_dx = COORD_BITS'(ax); it.ij_dy = COORD_BITS'(ay); it.ij_dz = COORD_BITS'(az);
		it.ik_dx = COORD_BITS'(bx); it.ik_dy = COORD_BITS'(by); it.ik_dz = COORD_BITS'(bz);
		it.bin_select = SEL_W'($urandom);
		return it;
	endfunction

	function automatic tadh_in_t read_item(input logic [SEL_W-1:0] sel);
		tadh_in_t it;
		it = random_item();
		it.mode = 1'b1;
		it.bin_select = sel;
		return it;
	endfunction

	task automatic random_phase(input int count);
		tadh_in_t it;
		int kind, reps, cx, cy, cz;
		for (int n = 0; n < count; n++) begin
			kind = $urandom_range(99);
			if (kind < 20) begin
				it = read_item(($urandom_range(1)) ? last_hit : SEL_W'($urandom));
			end else if (kind < 30) begin
				it = random_item();
				it.mode = 1'b0;
			end else if (kind < 35) begin
				cx = near_coord();
				cy = near_coord();
				cz = near_coord();
				if (kind < 33) it = tally(cx, cy, cz, cx, cy, cz);
				else it = tally(cx, cy, cz, 0, 0, 0);
			end else begin
				it = tally(near_coord(), near_coord(), near_coord(),
					near_coord(), near_coord(), near_coord());
			end
			reps = (kind >= 35 && $urandom_range(3) == 0) ? $urandom_range(1, 3) : 1;
			repeat (reps) send_item(it);
		end
	endtask

	initial begin
		in_valid = 1'b0;
		in_data = '0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		quiet = 1'b0;
		span = 32767;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		configure(0, 65536, 16, 32);

		send_item(tally(0, 0, 0, 0, 0, 0));
		send_item(tally(4096, 0, 0, 0, 4096, 0));
		send_item(tally(4096, 0, 0, -4096, 0, 0));
		send_item(tally(4096, 0, 0, -4096, 0, 0));
		send_item(read_item(last_hit));
		send_item(tally(4096, 4096, 0, 8192, 8192, 0));
		send_item(tally(4096, 8192, 0, 4096, 8192, 0));
		send_item(tally(8388607, 8388607, 8388607, 8388607, 8388607, -8388608));
		send_item(tally(-8388608, -8388608, -8388608, -8388608, -8388608, 8388607));
		send_item(tally(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
		send_item(tally(100000, 0, 0, 0, 5000, 0));
		send_item(tally(1, 0, 0, 0, 1, 0));
		send_item(tally(-3000, 2000, -1000, 1000, -2500, 3000));
		send_item(tally(-3000, 2000, -1000, 1000, -2500, 3000));
		send_item(read_item(last_hit));
		send_item(read_item(last_hit));
		send_item(read_item('0));
		send_item(read_item('1));
		send_item(tally(60000, 0, 0, 0, 60000, 0));
		random_phase(60);

		configure(0, 262144, 16, 32);
		quiet = 1'b1;
		random_phase(55);
		quiet = 1'b0;
		configure(2048, 65536, 8, 12);
		send_item(tally(1000, 0, 0, 0, 1000, 0));
		random_phase(55);
		configure(0, 0, 0, 0);
		random_phase(45);
		configure(32'h00FF_FFFF, 32'hFFFFFFFF, 31, 63);
		random_phase(35);
		configure(100, 32768, 31, 63);
		random_phase(55);
		configure(0, 1 << 20, 1, 1);
		random_phase(45);
		configure(4096, 65536 * 3, 16, 7);
		random_phase(55);

		drain();
		repeat (300) @(negedge clk);
		if (failures == 0 && pending == 0) begin
			$display("triplet_angle_distance_histogram_top_test passed");
		end else begin
			$display("triplet_angle_distance_histogram_top_test failed");
		end
		$finish;
	end
endmodule

[triplet_angle_distance_histogram_top.f]
+incdir+src
src/tadh_pkg.sv
src/tadh_ram.sv
src/tadh_sqrt.sv
src/tadh_cordic.sv
src/triplet_angle_distance_histogram_top.sv
bench/triplet_angle_distance_histogram_checker.sv
bench/triplet_angle_distance_histogram_top_test.sv
